[rtl/bss_pkg.sv]
// Shared types and constants for the byte substring search block.
package bss_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CFG_BITS = 64;
  localparam int LENGTH_BITS = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int RESULT_POS_BITS = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NEEDLE_LOW    = 2'd0,
    REG_NEEDLE_HIGH   = 2'd1,
    REG_NEEDLE_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                       found;
    logic [RESULT_POS_BITS-1:0] position;
  } result_t;

  typedef struct packed {
    logic                        full;
    logic                        empty;
    logic [QUEUE_COUNT_BITS-1:0] count;
  } queue_status_t;

endpackage

[rtl/bss_front.sv]
// Front end: config registers, byte window, position counter and needle compare.
module bss_front #(
  parameter int NEEDLE_MAX    = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bss_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bss_pkg::BYTE_BITS-1:0]        data_byte,
  input  logic                                 last_byte,
  input  bss_pkg::queue_status_t               q_status,
  output logic                                 push_valid,
  output bss_pkg::result_t                     push_data
);

  localparam int WIN  = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;
  localparam int LW   = $clog2(NEEDLE_MAX + 1);
  localparam int IW   = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int EXTW = (POSITION_BITS > bss_pkg::RESULT_POS_BITS) ?
                        POSITION_BITS : bss_pkg::RESULT_POS_BITS;

  logic [bss_pkg::CFG_BITS-1:0]    needle_low;
  logic [bss_pkg::CFG_BITS-1:0]    needle_high;
  logic [bss_pkg::LENGTH_BITS-1:0] needle_length;

  logic [bss_pkg::BYTE_BITS-1:0] recent [WIN];
  logic [POSITION_BITS-1:0]      byte_count;
  logic                          match_reported;

  logic [bss_pkg::BYTE_BITS-1:0] needle   [NEEDLE_MAX];
  logic [bss_pkg::BYTE_BITS-1:0] win_byte [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0]         ok;
  logic [LW-1:0]                 len_eff;
  logic [POSITION_BITS-1:0]      len_m1;
  logic [POSITION_BITS-1:0]      pos;
  logic [EXTW-1:0]               pos_ext;
  logic                          hit;
  logic                          accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low    <= '0;
      needle_high   <= '0;
      needle_length <= '0;
    end else if (cfg_write) begin
      case (bss_pkg::cfg_reg_t'(cfg_index))
        bss_pkg::REG_NEEDLE_LOW:    needle_low    <= cfg_data;
        bss_pkg::REG_NEEDLE_HIGH:   needle_high   <= cfg_data;
        bss_pkg::REG_NEEDLE_LENGTH: needle_length <= cfg_data[bss_pkg::LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // needle bytes beyond the two config words read as zero
  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_needle
    if (i < 8) begin : g_lo
      assign needle[i] = needle_low[bss_pkg::BYTE_BITS*i +: bss_pkg::BYTE_BITS];
    end else if (i < 16) begin : g_hi
      assign needle[i] = needle_high[bss_pkg::BYTE_BITS*(i-8) +: bss_pkg::BYTE_BITS];
    end else begin : g_zero
      assign needle[i] = '0;
    end
  end

  // offset 0 is the byte on the input, offset j the byte j places back
  assign win_byte[0] = data_byte;
  for (genvar j = 1; j < NEEDLE_MAX; j++) begin : g_win
    assign win_byte[j] = recent[j-1];
  end

  assign len_eff = (32'(needle_length) > NEEDLE_MAX) ? LW'(NEEDLE_MAX) : LW'(needle_length);

  for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cmp
    logic [LW-1:0] diff;
    assign diff  = len_eff - LW'(j + 1);
    assign ok[j] = (LW'(j) >= len_eff) || (needle[diff[IW-1:0]] == win_byte[j]);
  end

  assign len_m1  = POSITION_BITS'(len_eff) - 1'b1;
  assign hit     = (len_eff == '0) || ((byte_count >= len_m1) && (&ok));
  assign pos     = (len_eff == '0) ? '0 : byte_count - len_m1;
  assign pos_ext = EXTW'(pos);

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  assign push_valid         = accept && !match_reported && (hit || last_byte);
  assign push_data.found    = hit;
  assign push_data.position = hit ? pos_ext[bss_pkg::RESULT_POS_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      match_reported <= 1'b0;
      for (int k = 0; k < WIN; k++) recent[k] <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count     <= '0;
        match_reported <= 1'b0;
        for (int k = 0; k < WIN; k++) recent[k] <= '0;
      end else begin
        match_reported <= match_reported || hit;
        if (!(&byte_count)) byte_count <= byte_count + 1'b1;
        recent[0] <= data_byte;
        for (int k = 1; k < WIN; k++) recent[k] <= recent[k-1];
      end
    end
  end

endmodule

[rtl/bss_queue.sv]
// Two-entry result queue between the compare front end and the output stage.
module bss_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  input  bss_pkg::result_t       push_data,
  input  logic                   pop,
  output bss_pkg::result_t       pop_data,
  output bss_pkg::queue_status_t q_status
);

  bss_pkg::result_t                   entries [bss_pkg::QUEUE_DEPTH];
  logic [bss_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [bss_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [bss_pkg::QUEUE_COUNT_BITS-1:0] count;
  logic                               do_pop;

  assign q_status.count = count;
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == bss_pkg::QUEUE_COUNT_BITS'(bss_pkg::QUEUE_DEPTH));
  assign pop_data       = entries[rd_ptr];
  assign do_pop         = pop && !q_status.empty;

  always_ff @(posedge clk) begin
    if (push_valid) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)     rd_ptr <= rd_ptr + 1'b1;
      case ({push_valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/bss_back.sv]
// Output stage: holds one result beat until the consumer takes it.
module bss_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bss_pkg::queue_status_t                q_status,
  input  bss_pkg::result_t                      q_data,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  found,
  output logic [bss_pkg::RESULT_POS_BITS-1:0]   match_position
);

  bss_pkg::result_t held;

  assign pop            = !q_status.empty && (!out_valid || !out_stall);
  assign found          = held.found;
  assign match_position = held.position;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) held <= q_data;
  end

endmodule

[rtl/byte_substring_search.sv]
// Byte substring search: streams a haystack one byte per beat and reports the first
// occurrence of a configured needle of up to NEEDLE_MAX bytes. A byte is taken every
// clock cycle while in_stall is low: the whole window of the last NEEDLE_MAX-1 bytes plus
// the incoming byte is compared with the needle in parallel, so the compare and the
// window shift settle in the cycle the byte is accepted. A haystack gives exactly one
// result beat: found=1 with the start index on the first full match (the rest of that
// haystack is then consumed silently), or found=0 and position 0 on the byte flagged
// last_byte when nothing matched. An empty needle matches at position 0 on the first
// byte. The byte flagged last_byte rearms the search for the next haystack; the
// position counter saturates at all ones. Each result passes from the combinational
// compare through the two-deep queue into the output register. in_stall rises only
// when two results are queued behind a held output beat, which takes a consumer
// stalling across several haystacks. Config writes go straight into the needle registers
// and must only happen while no haystack is in flight. No clearing pass after reset.
module byte_substring_search #(
  parameter int NEEDLE_MAX    = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_write,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bss_pkg::CFG_BITS-1:0]        cfg_data,
  // haystack beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bss_pkg::BYTE_BITS-1:0]       data_byte,
  input  logic                                last_byte,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [bss_pkg::RESULT_POS_BITS-1:0] match_position
);

  logic                   push_valid;
  bss_pkg::result_t       push_data;
  logic                   pop;
  bss_pkg::result_t       q_data;
  bss_pkg::queue_status_t q_status;

  // front end: window, counter and compare; pushes at most one result per beat
  bss_front #(
    .NEEDLE_MAX    (NEEDLE_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_status   (q_status),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // decouples the byte stream from consumer back-pressure
  bss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .pop_data   (q_data),
    .q_status   (q_status)
  );

  // registered output beat
  bss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .q_data         (q_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .found          (found),
    .match_position (match_position)
  );

  // a not-found beat always carries position zero
  a_notfound_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_position == '0))
    else $error("not-found result with non-zero position");

  // queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (q_status.count <= bss_pkg::QUEUE_COUNT_BITS'(bss_pkg::QUEUE_DEPTH)))
    else $error("result queue overflow");

  // a queued result reaches an empty output register on the next cycle
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !q_status.empty) |=> out_valid)
    else $error("queued result not moved to output");

endmodule
